// File: rtl/pfm_pkg.sv
// Package for the power stage fault monitor: field widths, register indexes,
// the limit and check status structs and the limit unpacking function.
// Depends on nothing; every other file of the block imports it.
package pfm_pkg;

  localparam int NUM_CHECKS      = 5;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int MEAS_W          = 16;
  localparam int EXT_W           = MEAS_W + 1;
  localparam int DLY_W           = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_ADDR_W      = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_IDX_LSB     = 3;
  localparam int CNT_OUT_W       = 3;

  // Register indexes, also the check numbers.
  localparam logic [CFG_IDX_W-1:0] IDX_VIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_VOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_IOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_HOT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_COLD = 3'd4;

  // Limits of one check, each threshold extended to a common signed width.
  typedef struct packed {
    logic [DLY_W-1:0]        delay;
    logic signed [EXT_W-1:0] recovery;
    logic signed [EXT_W-1:0] normal;
    logic signed [EXT_W-1:0] instant;
  } lim_t;

  typedef struct packed {
    logic trip;
    logic fault;
  } chk_status_t;

  // Splits a limit register; the thresholds are sign extended when sgn is set.
  function automatic lim_t unpack_limits(input logic [CFG_DATA_W-1:0] raw,
                                         input logic sgn);
    lim_t l;
    l.instant  = {sgn & raw[15], raw[15:0]};
    l.normal   = {sgn & raw[31], raw[31:16]};
    l.recovery = {sgn & raw[47], raw[47:32]};
    l.delay    = raw[63:48];
    return l;
  endfunction

endpackage

// File: rtl/pfm_if.sv
// Request channels of the power stage fault monitor: the measurement tick
// channel and the fault result channel. Depends on pfm_pkg.
interface pfm_in_if;
  import pfm_pkg::*;
  logic              valid;
  logic              ready;
  logic [MEAS_W-1:0] vin;
  logic [MEAS_W-1:0] vout;
  logic [MEAS_W-1:0] iout;
  logic signed [MEAS_W-1:0] temp;

  modport source (output valid, vin, vout, iout, temp, input ready);
  modport sink   (input valid, vin, vout, iout, temp, output ready);
endinterface

interface pfm_out_if;
  import pfm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 vin_over_fault;
  logic                 vout_over_fault;
  logic                 iout_over_fault;
  logic                 hot_fault;
  logic                 cold_fault;
  logic [CNT_OUT_W-1:0] fault_count;
  logic                 stop_request;

  modport source (output valid, vin_over_fault, vout_over_fault, iout_over_fault,
                  hot_fault, cold_fault, fault_count, stop_request, input ready);
  modport sink   (input valid, vin_over_fault, vout_over_fault, iout_over_fault,
                  hot_fault, cold_fault, fault_count, stop_request, output ready);
endinterface

// File: rtl/power_stage_fault_monitor.sv
// Top level of the power stage fault monitor: tick input register, five
// limit checks, result register and the limit register file.
// Depends on pfm_pkg, pfm_if, pfm_cfg_regs and pfm_check.
//
//   Channel   Direction  Handshake                 Payload
//   in_ch     sink       valid / ready             vin, vout, iout, temp
//   out_ch    source     valid / ready             five fault flags, fault_count,
//                                                  stop_request
//   cfg (APB) slave      psel, penable, pready=1   64-bit limit registers, 8*i
//
// One tick is accepted in every cycle while the result side keeps up. Its result
// is held in the input register, passes the single compare-and-count stage and
// is then offered from the result register; a stall on out_ch can hold it in
// the input register before it moves on to the result register.
// Synchronous active-low reset empties both registers and clears the
// persistence counters, fault flags and limits.
// When out_ch stalls, the result register holds its request and the input
// register can still take one more tick before in_ch.ready falls.
module power_stage_fault_monitor #(
  parameter int COUNT_WIDTH = pfm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pfm_in_if.sink                         in_ch,
  pfm_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import pfm_pkg::*;

  // Limit registers.
  logic [CFG_DATA_W-1:0] limits [NUM_CHECKS];

  pfm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  // Input register: holds one accepted tick until the result register is free.
  logic                     s1_valid_r;
  logic [MEAS_W-1:0]        vin_r, vout_r, iout_r;
  logic signed [MEAS_W-1:0] temp_r;
  logic                     res_free;
  logic                     step_en;
  logic                     in_fire;

  // Result register.
  logic                 out_valid_r;
  logic [NUM_CHECKS-1:0] flags_r;
  logic [CNT_OUT_W-1:0]  count_r;
  logic                 stop_r;

  assign res_free     = !out_valid_r || out_ch.ready;
  assign step_en      = s1_valid_r && res_free;
  assign in_ch.ready  = !s1_valid_r || res_free;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      vin_r  <= in_ch.vin;
      vout_r <= in_ch.vout;
      iout_r <= in_ch.iout;
      temp_r <= in_ch.temp;
    end
  end

  // Each check compares on a common 17-bit signed scale: voltages and current
  // are zero extended, the temperature is sign extended.
  logic signed [EXT_W-1:0] value [NUM_CHECKS];
  chk_status_t             status [NUM_CHECKS];
  logic [NUM_CHECKS-1:0]   flags_nxt;
  logic [NUM_CHECKS-1:0]   trips;

  assign value[IDX_VIN]  = {1'b0, vin_r};
  assign value[IDX_VOUT] = {1'b0, vout_r};
  assign value[IDX_IOUT] = {1'b0, iout_r};
  assign value[IDX_HOT]  = {temp_r[MEAS_W-1], temp_r};
  assign value[IDX_COLD] = {temp_r[MEAS_W-1], temp_r};

  for (genvar g = 0; g < NUM_CHECKS; g++) begin : g_check
    pfm_check #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .UNDER       (g == int'(IDX_COLD))
    ) u_check (
      .clk     (clk),
      .rst_n   (rst_n),
      .step_en (step_en),
      .value   (value[g]),
      .lim     (unpack_limits(limits[g], g >= int'(IDX_HOT))),
      .status  (status[g])
    );
    assign flags_nxt[g] = status[g].fault;
    assign trips[g]     = status[g].trip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // A trip that recovers on the same tick still raises the stop request.
  always_ff @(posedge clk) begin
    if (step_en) begin
      flags_r <= flags_nxt;
      count_r <= CNT_OUT_W'($countones(flags_nxt));
      stop_r  <= |trips;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.vin_over_fault  = flags_r[IDX_VIN];
  assign out_ch.vout_over_fault = flags_r[IDX_VOUT];
  assign out_ch.iout_over_fault = flags_r[IDX_IOUT];
  assign out_ch.hot_fault       = flags_r[IDX_HOT];
  assign out_ch.cold_fault      = flags_r[IDX_COLD];
  assign out_ch.fault_count     = count_r;
  assign out_ch.stop_request    = stop_r;

  // Reset leaves both pipeline registers empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !s1_valid_r)
    else $error("pipeline not empty after reset");

  // A tick may enter a full input register only while that one moves on.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && s1_valid_r |-> res_free)
    else $error("input register overwritten");

  // The delivered count always matches the delivered flags.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.fault_count == CNT_OUT_W'($countones(flags_r)))
    else $error("fault count does not match fault flags");

endmodule

// File: rtl/pfm_cfg_regs.sv
// APB-style limit register file of the power stage fault monitor.
// Holds the five 64-bit limit registers at byte address 8*i. Depends on pfm_pkg.
module pfm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [pfm_pkg::CFG_DATA_W-1:0] limits [pfm_pkg::NUM_CHECKS]
);
  import pfm_pkg::*;

  logic [CFG_DATA_W-1:0] limits_r [NUM_CHECKS];
  logic [CFG_IDX_W-1:0]  idx;
  logic                  wr_en;

  assign idx    = paddr[CFG_IDX_LSB +: CFG_IDX_W];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHECKS; i++) begin
        limits_r[i] <= '0;
      end
    end else if (wr_en) begin
      for (int i = 0; i < NUM_CHECKS; i++) begin
        if (idx == CFG_IDX_W'(i)) begin
          limits_r[i] <= pwdata;
        end
      end
    end
  end

  // Addresses past the last register read as zero.
  always_comb begin
    prdata = '0;
    for (int i = 0; i < NUM_CHECKS; i++) begin
      if (idx == CFG_IDX_W'(i)) begin
        prdata = limits_r[i];
      end
    end
  end

  assign limits = limits_r;

endmodule

// File: rtl/pfm_check.sv
// One limit check of the power stage fault monitor: instant trip, delayed
// trip with a saturating persistence counter, and recovery. Depends on pfm_pkg.
module pfm_check #(
  parameter int COUNT_WIDTH = pfm_pkg::COUNT_WIDTH_DEF,
  parameter bit UNDER       = 1'b0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_en,
  input  logic signed [pfm_pkg::EXT_W-1:0] value,
  input  pfm_pkg::lim_t                    lim,
  output pfm_pkg::chk_status_t             status
);
  import pfm_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > DLY_W) ? COUNT_WIDTH : DLY_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic signed [EXT_W-1:0] inst_lim;
  logic signed [EXT_W-1:0] norm_lim;
  logic signed [EXT_W-1:0] recv_lim;
  logic [COUNT_WIDTH-1:0]  cnt_r, cnt_nxt;
  logic                    fault_r, fault_nxt;
  logic                    inst_hit, norm_hit, recv_hit, delay_hit, trip;

  assign inst_lim = lim.instant;
  assign norm_lim = lim.normal;
  assign recv_lim = lim.recovery;

  assign inst_hit = UNDER ? (value < inst_lim) : (value > inst_lim);
  assign norm_hit = UNDER ? (value < norm_lim) : (value > norm_lim);
  assign recv_hit = UNDER ? (value > recv_lim) : (value < recv_lim);

  // The counter sticks at its top value instead of wrapping.
  assign cnt_nxt   = !norm_hit ? '0 :
                     (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign delay_hit = norm_hit && (CMP_W'(cnt_nxt) >= CMP_W'(lim.delay));
  assign trip      = inst_hit || delay_hit;

  // Recovery overrides a trip on the same tick.
  assign fault_nxt = (fault_r || trip) && !recv_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      fault_r <= 1'b0;
    end else if (step_en) begin
      cnt_r   <= cnt_nxt;
      fault_r <= fault_nxt;
    end
  end

  assign status.trip  = trip;
  assign status.fault = fault_nxt;

endmodule

// File: test/pfm_tb_pkg.sv
// Scoreboard for the power stage fault monitor testbench: tick and verdict
// types, the fault predictor and the queue of verdicts still owed.
// Depends on pfm_pkg for widths and check indexes.
package pfm_tb_pkg;
  import pfm_pkg::*;

  typedef struct {
    logic [MEAS_W-1:0]        vin;
    logic [MEAS_W-1:0]        vout;
    logic [MEAS_W-1:0]        iout;
    logic signed [MEAS_W-1:0] temp;
  } tick_t;

  // Fault flags are held by check index.
  typedef struct {
    logic [NUM_CHECKS-1:0] faults;
    logic [CNT_OUT_W-1:0]  count;
    logic                  stop;
  } verdict_t;

  class fault_tracker;
    logic [CFG_DATA_W-1:0] limit_reg [NUM_CHECKS];
    int unsigned           persist [NUM_CHECKS];
    bit                    latched [NUM_CHECKS];
    int unsigned           cnt_top;
    string                 flag_name [NUM_CHECKS];
    verdict_t              owed_verdicts [$];
    int                    errors;

    function new();
      cnt_top = (COUNT_WIDTH_DEF >= 32) ? 32'hFFFF_FFFF : (32'd1 << COUNT_WIDTH_DEF) - 1;
      foreach (limit_reg[k]) begin
        limit_reg[k] = '0;
        persist[k]   = 0;
        latched[k]   = 1'b0;
      end
      flag_name[IDX_VIN]  = "vin_over_fault";
      flag_name[IDX_VOUT] = "vout_over_fault";
      flag_name[IDX_IOUT] = "iout_over_fault";
      flag_name[IDX_HOT]  = "hot_fault";
      flag_name[IDX_COLD] = "cold_fault";
      errors  = 0;
    endfunction

    // Writes outside the register file are dropped, as the block does.
    function void write_limit(int unsigned idx, logic [CFG_DATA_W-1:0] value);
      if (idx < NUM_CHECKS)
        limit_reg[idx] = value;
    endfunction

    function int threshold(logic [15:0] raw, bit sgn);
      return sgn ? int'(signed'(raw)) : int'(raw);
    endfunction

    // One limit check; returns whether it tripped on this tick.
    function bit judge(int k, int val, bit sgn, bit under);
      int          inst;
      int          norm;
      int          recv;
      int unsigned dly;
      bit          trip;
      inst = threshold(limit_reg[k][15:0], sgn);
      norm = threshold(limit_reg[k][31:16], sgn);
      recv = threshold(limit_reg[k][47:32], sgn);
      dly  = limit_reg[k][63:48];
      trip = under ? (val < inst) : (val > inst);
      if (under ? (val < norm) : (val > norm)) begin
        if (persist[k] < cnt_top)
          persist[k]++;
        if (persist[k] >= dly)
          trip = 1'b1;
      end else begin
        persist[k] = 0;
      end
      if (trip)
        latched[k] = 1'b1;
      // Recovery is applied last, so it beats a trip on the same tick.
      if (under ? (val > recv) : (val < recv))
        latched[k] = 1'b0;
      return trip;
    endfunction

    function void note_tick(tick_t t);
      verdict_t v;
      bit       trips [NUM_CHECKS];
      int       count;
      trips[IDX_VIN]  = judge(IDX_VIN, int'(t.vin), 1'b0, 1'b0);
      trips[IDX_VOUT] = judge(IDX_VOUT, int'(t.vout), 1'b0, 1'b0);
      trips[IDX_IOUT] = judge(IDX_IOUT, int'(t.iout), 1'b0, 1'b0);
      trips[IDX_HOT]  = judge(IDX_HOT, int'(t.temp), 1'b1, 1'b0);
      trips[IDX_COLD] = judge(IDX_COLD, int'(t.temp), 1'b1, 1'b1);
      count  = 0;
      v.stop = 1'b0;
      foreach (latched[k]) begin
        v.faults[k] = latched[k];
        count += latched[k];
        v.stop |= trips[k];
      end
      v.count = CNT_OUT_W'(count);
      owed_verdicts.push_back(v);
    endfunction

    function int pending();
      return owed_verdicts.size();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_verdict(verdict_t got);
      verdict_t want;
      if (owed_verdicts.size() == 0) begin
        report("fault result with no tick outstanding");
        return;
      end
      want = owed_verdicts.pop_front();
      foreach (flag_name[k]) begin
        if (got.faults[k] !== want.faults[k])
          report($sformatf("%s is %b, predicted %b", flag_name[k], got.faults[k],
                           want.faults[k]));
      end
      if (got.count !== want.count)
        report($sformatf("fault_count is %0d, predicted %0d", got.count, want.count));
      if (got.stop !== want.stop)
        report($sformatf("stop_request is %b, predicted %b", got.stop, want.stop));
    endtask
  endclass

endpackage

// File: test/testbench.sv
// Top level testbench for the power stage fault monitor: clock, reset, tick
// and result channels, APB limit programming and the stimulus phases.
// Depends on pfm_pkg, pfm_if, pfm_tb_pkg and the power_stage_fault_monitor RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pfm_pkg::*;
  import pfm_tb_pkg::*;

  // Ways of filling a limit register for a phase.
  localparam int LIM_ZERO   = 0;
  localparam int LIM_ONES   = 1;
  localparam int LIM_NOISE  = 2;
  localparam int LIM_BANDED = 3;

  // Spare cycles waited once every verdict is back from the result register.
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASES          = 7;
  localparam int TICKS_PER_PHASE = 200;
  // Length of the closing back-to-back run, and the delay that it must reach.
  localparam int LONG_RUN_TICKS  = 200;
  localparam int LONG_RUN_DELAY  = 150;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  pfm_in_if  tick_ch ();
  pfm_out_if verdict_ch ();

  power_stage_fault_monitor u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (tick_ch),
    .out_ch  (verdict_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fault_tracker tracker = new();

  // Idle bursts on the tick side and stalls on the result side are switched
  // per phase, so that some stretches run back to back.
  bit src_idle_on;
  bit snk_idle_on;

  // Shadow of the limit registers, used for read-back and for aiming the
  // random measurements at the thresholds.
  logic [CFG_DATA_W-1:0] cur_lim [NUM_CHECKS];

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("power_stage_fault_monitor regression: fail");
    $finish;
  end

  // Result side: ready is changed at the falling edge and drops for random bursts
  // while stalls are enabled.
  initial begin : result_pacing
    int stall_left;
    stall_left       = 0;
    verdict_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && snk_idle_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
        verdict_ch.ready = 1'b0;
        stall_left--;
      end else begin
        verdict_ch.ready = 1'b1;
      end
    end
  end

  // Every result request accepted at a rising edge is checked against the
  // oldest verdict still owed.
  always @(posedge clk) begin : result_monitor
    verdict_t got;
    if (rst_n && verdict_ch.valid && verdict_ch.ready) begin
      got.faults[IDX_VIN]  = verdict_ch.vin_over_fault;
      got.faults[IDX_VOUT] = verdict_ch.vout_over_fault;
      got.faults[IDX_IOUT] = verdict_ch.iout_over_fault;
      got.faults[IDX_HOT]  = verdict_ch.hot_fault;
      got.faults[IDX_COLD] = verdict_ch.cold_fault;
      got.count            = verdict_ch.fault_count;
      got.stop             = verdict_ch.stop_request;
      tracker.check_verdict(got);
    end
  end

  // Offers one tick request, possibly after an idle burst, and hands it to the
  // predictor at the edge where it is taken.
  task automatic send_tick(input logic [15:0] vin, input logic [15:0] vout,
                           input logic [15:0] iout, input logic signed [15:0] temp);
    tick_t t;
    int    gap;
    t.vin  = vin;
    t.vout = vout;
    t.iout = iout;
    t.temp = temp;
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap           = $urandom_range(1, 6);
      tick_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid = 1'b1;
    tick_ch.vin   = t.vin;
    tick_ch.vout  = t.vout;
    tick_ch.iout  = t.iout;
    tick_ch.temp  = t.temp;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
    tracker.note_tick(t);
  endtask

  // Stops offering ticks and waits until every verdict has come back, then a
  // few cycles more so that the block is truly idle.
  task automatic wait_drained();
    @(negedge clk);
    tick_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value at
  // the edge where the access phase meets pready.
  task automatic cfg_write(input int unsigned idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_ADDR_W'(idx << CFG_IDX_LSB);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    tracker.write_limit(idx, value);
    if (idx < NUM_CHECKS)
      cur_lim[idx] = value;
  endtask

  // Writes a limit register and reads it back over the same port.
  task automatic set_limit(input int unsigned idx, input logic [CFG_DATA_W-1:0] value);
    cfg_write(idx, value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = CFG_ADDR_W'(idx << CFG_IDX_LSB);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== cur_lim[idx])
      tracker.report($sformatf("limit register %0d reads %h, written %h", idx, prdata,
                               cur_lim[idx]));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Builds a limit register. The banded form puts recovery, normal and instant
  // limits close together so that random values cross all three; now and then
  // the recovery limit lies beyond the instant limit, so that a tick can trip
  // and clear at once.
  function automatic logic [CFG_DATA_W-1:0] make_limits(input int k, input int mode);
    bit          sgn;
    bit          under;
    int          base;
    int          inst;
    int          recv;
    int          lo_gap;
    int          hi_gap;
    logic [15:0] dly;
    sgn   = (k == IDX_HOT) || (k == IDX_COLD);
    under = (k == IDX_COLD);
    case (mode)
      LIM_ZERO:  return '0;
      LIM_ONES:  return '1;
      LIM_NOISE: return {$urandom, $urandom};
      default: begin
        base   = sgn ? int'($urandom_range(0, 6000)) - 3000 : int'($urandom_range(200, 65335));
        lo_gap = $urandom_range(1, 100);
        hi_gap = $urandom_range(1, 100);
        inst   = under ? base - hi_gap : base + hi_gap;
        recv   = under ? base + lo_gap : base - lo_gap;
        if ($urandom_range(0, 7) == 0)
          recv = under ? inst - 5 : inst + 5;
        case ($urandom_range(0, 7))
          0:       dly = 16'h0000;
          1:       dly = 16'hFFFF;
          default: dly = 16'($urandom_range(1, 6));
        endcase
        return {dly, recv[15:0], base[15:0], inst[15:0]};
      end
    endcase
  endfunction

  // A measurement level close to one of the thresholds of check k, or now and
  // then anywhere in the field's range.
  function automatic logic [15:0] near_limit(input int k);
    int sel;
    sel = $urandom_range(0, 3);
    if (sel == 3)
      return 16'($urandom);
    return cur_lim[k][16*sel +: 16] + 16'($urandom_range(0, 6)) - 16'd3;
  endfunction

  initial begin : stimulus
    logic [15:0] lvl_vin;
    logic [15:0] lvl_vout;
    logic [15:0] lvl_iout;
    logic [15:0] lvl_temp;
    int          ph;
    int          n;
    int          k;
    int          mode;

    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tick_ch.valid = 1'b0;
    tick_ch.vin   = '0;
    tick_ch.vout  = '0;
    tick_ch.iout  = '0;
    tick_ch.temp  = '0;
    src_idle_on   = 1'b0;
    snk_idle_on   = 1'b0;
    for (k = 0; k < NUM_CHECKS; k++)
      cur_lim[k] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Limits still at their reset value of zero: every non-zero voltage or
    // current trips, a positive temperature trips the hot check and a negative
    // one trips the cold check while clearing the hot one.
    send_tick(16'd0, 16'd0, 16'd0, 16'sd0);
    send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF);
    send_tick(16'd0, 16'd0, 16'd0, 16'sh8000);
    send_tick(16'd1, 16'd1, 16'd1, 16'sd0);

    // A hand-picked setting: input over-voltage needs three ticks in a row,
    // output over-voltage recovers above its instant limit, output over-current
    // trips on the first tick past normal, and the temperature limits are
    // positive for the hot check and negative for the cold one.
    wait_drained();
    set_limit(IDX_VIN,  {16'd3, 16'd30000, 16'd40000, 16'd50000});
    set_limit(IDX_VOUT, {16'd1, 16'd5000, 16'd2000, 16'd1000});
    set_limit(IDX_IOUT, {16'd0, 16'd8000, 16'd10000, 16'd60000});
    set_limit(IDX_HOT,  {16'd2, 16'd600, 16'd800, 16'd1000});
    set_limit(IDX_COLD, {16'd2, 16'(-100), 16'(-300), 16'(-500)});

    send_tick(16'd35000, 16'd500, 16'd100, 16'sd25);
    repeat (3) send_tick(16'd45000, 16'd500, 16'd100, 16'sd25);
    send_tick(16'd35000, 16'd500, 16'd100, 16'sd25);
    send_tick(16'd29999, 16'd500, 16'd100, 16'sd25);
    send_tick(16'd50001, 16'd500, 16'd100, 16'sd25);
    send_tick(16'd35000, 16'd3000, 16'd100, 16'sd25);
    send_tick(16'd35000, 16'd500, 16'd10001, 16'sd25);
    send_tick(16'd35000, 16'd500, 16'd7999, 16'sd1001);
    send_tick(16'd35000, 16'd500, 16'd100, 16'sd599);
    send_tick(16'd35000, 16'd500, 16'd100, -16'sd501);
    send_tick(16'd35000, 16'd500, 16'd100, -16'sd99);
    send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF);
    send_tick(16'd0, 16'd0, 16'd0, 16'sh8000);

    // Writes above the last register must not land anywhere; any aliasing
    // shows up in the checks that follow.
    wait_drained();
    for (k = NUM_CHECKS; k < (1 << CFG_IDX_W); k++)
      cfg_write(k, {$urandom, $urandom});

    // Random phases. The first two use the all-zero and all-ones extremes, one
    // uses random register contents, the rest banded limits or now and then random
    // ones. Measurement levels are held for a few ticks at a time, so that the
    // persistence counters see runs of consecutive ticks past the normal limit.
    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      src_idle_on = (ph % 3) != 2;
      snk_idle_on = src_idle_on;
      for (k = 0; k < NUM_CHECKS; k++) begin
        if (ph == 0)
          mode = LIM_ZERO;
        else if (ph == 1)
          mode = LIM_ONES;
        else if (ph == 4 || $urandom_range(0, 9) == 0)
          mode = LIM_NOISE;
        else
          mode = LIM_BANDED;
        set_limit(k, make_limits(k, mode));
      end
      for (n = 0; n < TICKS_PER_PHASE; n++) begin
        if (n == 0 || $urandom_range(0, 4) == 0)
          lvl_vin = near_limit(IDX_VIN);
        if (n == 0 || $urandom_range(0, 4) == 0)
          lvl_vout = near_limit(IDX_VOUT);
        if (n == 0 || $urandom_range(0, 4) == 0)
          lvl_iout = near_limit(IDX_IOUT);
        if (n == 0 || $urandom_range(0, 4) == 0)
          lvl_temp = near_limit($urandom_range(0, 1) ? IDX_HOT : IDX_COLD);
        if ($urandom_range(0, 9) == 0)
          send_tick(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
          send_tick(lvl_vin + 16'($urandom_range(0, 2)) - 16'd1,
                    lvl_vout + 16'($urandom_range(0, 2)) - 16'd1,
                    lvl_iout + 16'($urandom_range(0, 2)) - 16'd1,
                    lvl_temp + 16'($urandom_range(0, 2)) - 16'd1);
      end
    end

    // Last part, with no idling on either side: the input voltage stays above
    // a normal limit of zero on every tick, so its persistence counter climbs
    // without a break and the delayed trip fires only late in the run.
    wait_drained();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    set_limit(IDX_VIN, {16'(LONG_RUN_DELAY), 16'h0000, 16'h0000, 16'hFFFF});
    for (k = IDX_VOUT; k < NUM_CHECKS; k++)
      set_limit(k, make_limits(k, LIM_BANDED));
    for (n = 0; n < LONG_RUN_TICKS; n++)
      send_tick(16'($urandom_range(1, 65535)), near_limit(IDX_VOUT), near_limit(IDX_IOUT),
                near_limit($urandom_range(0, 1) ? IDX_HOT : IDX_COLD));

    wait_drained();
    if (tracker.errors == 0)
      $display("power_stage_fault_monitor regression: pass");
    else
      $display("power_stage_fault_monitor regression: fail");
    $finish;
  end

endmodule
